>>> hw/rtl/modinv_pkg.sv
// shared types, constants and control structs for the modular inverse block
package modinv_pkg;

	// word width of value, modulus, inverse and gcd
	localparam int WORD_BITS = 32;
	// bit counter width for the shift-subtract divider
	localparam int CNT_W = $clog2(WORD_BITS);

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [CNT_W-1:0]     cnt_t;

	// last step index of one division
	localparam cnt_t CNT_LAST = cnt_t'(WORD_BITS - 1);

	// input transaction
	typedef struct packed {
		word_t value;
		word_t modulus;
	} operand_t;

	// output transaction
	typedef struct packed {
		word_t inverse;
		logic  has_inverse;
		word_t gcd_value;
	} result_t;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TEST,
		ST_DIVIDE,
		ST_UPDATE,
		ST_FINISH
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic div_start;
		logic div_step;
		logic update;
		logic finish;
	} dp_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic nr_zero;
		logic out_busy;
	} dp_sts_t;

endpackage

>>> hw/rtl/modinv_ctrl.sv
// controller state machine sequencing the euclid rounds and the divider steps
module modinv_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               operand_valid,
	output logic               operand_stall,
	input  modinv_pkg::dp_sts_t sts,
	output modinv_pkg::dp_cmd_t cmd
);
	import modinv_pkg::*;

	state_t state_q, state_d;
	cnt_t   cnt_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// divider step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_start) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + cnt_t'(1);
		end
	end

	// next state and commands
	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		operand_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				operand_stall = 1'b0;
				if (operand_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_TEST;
				end
			end
			ST_TEST: begin
				if (sts.nr_zero) begin
					state_d = ST_FINISH;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_LAST) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = ST_TEST;
			end
			ST_FINISH: begin
				if (!sts.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef ASSERT_OFF
	// a result is never written over one still waiting downstream
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !sts.out_busy)
		else $error("finish issued while output register busy");

	// a round update follows a complete division
	a_full_division: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE) |-> ($past(state_q) == ST_DIVIDE && $past(cnt_q) == CNT_LAST))
		else $error("update without a full division");
`endif

endmodule

>>> hw/rtl/modinv_dp.sv
// datapath: remainder and cofactor registers, shift-subtract divider, output register
module modinv_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  modinv_pkg::operand_t operand,
	input  modinv_pkg::dp_cmd_t  cmd,
	output modinv_pkg::dp_sts_t  sts,
	output modinv_pkg::result_t  result,
	output logic                result_valid,
	input  logic                result_stall
);
	import modinv_pkg::*;

	word_t   m_q, r_q, nr_q;
	word_t   t_q, nt_q;
	logic    t_neg_q, nt_neg_q;
	word_t   p_q, d_q, acc_q;
	result_t rsp_q;
	logic    rsp_valid_q;

	logic [WORD_BITS:0] shifted, diff;
	logic               qbit;
	word_t              p_next, acc_next;
	logic               ok;
	word_t              inv_sel;
	result_t            rsp_d;

	// one restoring division step, quotient bit folded into q*nt on the fly
	always_comb begin
		shifted  = {p_q, d_q[WORD_BITS-1]};
		diff     = shifted - {1'b0, nr_q};
		qbit     = ~diff[WORD_BITS];
		p_next   = qbit ? diff[WORD_BITS-1:0] : shifted[WORD_BITS-1:0];
		acc_next = {acc_q[WORD_BITS-2:0], 1'b0} + (qbit ? nt_q : '0);
	end

	// final result from the last nonzero remainder and its cofactor
	always_comb begin
		ok      = (r_q <= word_t'(1));
		inv_sel = (t_neg_q && (t_q != '0)) ? (m_q - t_q) : t_q;
		rsp_d.inverse     = ok ? inv_sel : '0;
		rsp_d.has_inverse = ok;
		rsp_d.gcd_value   = r_q;
	end

	// remainder pair and cofactors
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			m_q      <= operand.modulus;
			r_q      <= operand.modulus;
			nr_q     <= operand.value;
			t_q      <= '0;
			nt_q     <= word_t'(1);
			t_neg_q  <= 1'b1;
			nt_neg_q <= 1'b0;
		end else if (cmd.update) begin
			r_q      <= nr_q;
			nr_q     <= p_q;
			t_q      <= nt_q;
			nt_q     <= acc_q + t_q;
			t_neg_q  <= nt_neg_q;
			nt_neg_q <= ~nt_neg_q;
		end
	end

	// divider registers
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			p_q   <= '0;
			d_q   <= r_q;
			acc_q <= '0;
		end else if (cmd.div_step) begin
			p_q   <= p_next;
			d_q   <= {d_q[WORD_BITS-2:0], 1'b0};
			acc_q <= acc_next;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			rsp_q <= rsp_d;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			rsp_valid_q <= 1'b1;
		end else if (!result_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign sts.nr_zero   = (nr_q == '0);
	assign sts.out_busy  = rsp_valid_q && result_stall;
	assign result        = rsp_q;
	assign result_valid  = rsp_valid_q;

`ifndef ASSERT_OFF
	// partial remainder stays below the divisor
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |=> (p_q < nr_q))
		else $error("partial remainder not below divisor");

	// a result shows up only after a finish command
	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(cmd.finish))
		else $error("result valid without finish");

	// an inverse is flagged only for a unit or zero gcd
	a_flag_gcd: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (!rsp_q.has_inverse || (rsp_q.gcd_value <= word_t'(1))))
		else $error("inverse flagged with gcd above one");
`endif

endmodule

>>> hw/rtl/modular_inverse_32.sv
// top level of the extended euclidean modular inverse block
//
//   channel   valid           stall           payload
//   operand   operand_valid   operand_stall   operand (value, modulus)
//   result    result_valid    result_stall    result (inverse, has_inverse, gcd_value)
//
// one transaction at a time; each euclid round passes test, divide and update,
// with divide driven by the one-bit-per-cycle shift-subtract divider
// per item: load, rounds until the remainder is zero, finish when the output is free
// a new operand is taken as soon as the previous result sits in the output register
// reset clears only the controller and the output valid; no clearing pass
// result_stall holds the finished result and delays the next completion only
module modular_inverse_32 (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 operand_valid,
	output logic                 operand_stall,
	input  modinv_pkg::operand_t operand,
	output logic                 result_valid,
	input  logic                 result_stall,
	output modinv_pkg::result_t  result
);
	import modinv_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// controller
	modinv_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.operand_valid (operand_valid),
		.operand_stall (operand_stall),
		.sts           (sts),
		.cmd           (cmd)
	);

	// datapath
	modinv_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.operand      (operand),
		.cmd          (cmd),
		.sts          (sts),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

endmodule

>>> tb/testbench.sv
// self-checking testbench for the modular_inverse_32 extended euclid block
module testbench;
	import modinv_pkg::*;

	localparam int          RANDOM_ITEMS = 370;
	localparam int          CALM_TAIL    = 40;
	localparam int          DRAIN_CYCLES = 1700;
	localparam bit [63:0]   WORD_MASK    = (64'd1 << WORD_BITS) - 64'd1;
	localparam word_t       WORD_MAX     = '1;

	// expected inverse results, kept in arrival order of operands
	class inverse_checker;
		result_t pending_inverses[$];
		int      mismatches;
		int      with_inverse;
		int      without_inverse;

		// extended euclid with sign-magnitude cofactors
		function result_t euclid_inverse(operand_t op);
			bit [63:0] rem_a, rem_b, cof_a, cof_b, quot, rest, cof_next;
			bit        neg_a, neg_b;
			result_t   res;
			rem_a = 64'(op.modulus);
			rem_b = 64'(op.value);
			cof_a = 64'd0;
			cof_b = 64'd1;
			neg_a = 1'b1;
			neg_b = 1'b0;
			while (rem_b != 64'd0) begin
				quot     = rem_a / rem_b;
				rest     = rem_a % rem_b;
				cof_next = (cof_a + quot * cof_b) & WORD_MASK;
				cof_a    = cof_b;
				neg_a    = neg_b;
				cof_b    = cof_next;
				neg_b    = !neg_b;
				rem_a    = rem_b;
				rem_b    = rest;
			end
			res.gcd_value = rem_a[WORD_BITS-1:0];
			if (rem_a > 64'd1) begin
				res.inverse     = '0;
				res.has_inverse = 1'b0;
			end else begin
				res.has_inverse = 1'b1;
				// a zero magnitude is never raised by the modulus
				if (neg_a && cof_a != 64'd0)
					res.inverse = word_t'((64'(op.modulus) - cof_a) & WORD_MASK);
				else
					res.inverse = word_t'(cof_a);
			end
			return res;
		endfunction

		function void note(operand_t op);
			pending_inverses.push_back(euclid_inverse(op));
		endfunction

		function void check(result_t got);
			result_t want;
			if (pending_inverses.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
				mismatches++;
				return;
			end
			want = pending_inverses.pop_front();
			if (got.inverse !== want.inverse) begin
				$display("%0t: inverse mismatch, expected %h, actual %h",
					$time, want.inverse, got.inverse);
				mismatches++;
			end
			if (got.has_inverse !== want.has_inverse) begin
				$display("%0t: has_inverse mismatch, expected %b, actual %b",
					$time, want.has_inverse, got.has_inverse);
				mismatches++;
			end
			if (got.gcd_value !== want.gcd_value) begin
				$display("%0t: gcd_value mismatch, expected %h, actual %h",
					$time, want.gcd_value, got.gcd_value);
				mismatches++;
			end
			if (want.has_inverse)
				with_inverse++;
			else
				without_inverse++;
		endfunction

		function int outstanding();
			return pending_inverses.size();
		endfunction
	endclass

	logic     clk = 1'b0;
	logic     arst_n;
	logic     operand_valid;
	logic     operand_stall;
	operand_t operand;
	logic     result_valid;
	logic     result_stall;
	result_t  result;

	inverse_checker checker_h;
	bit             calm;
	int             stall_left;

	modular_inverse_32 i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.operand_valid (operand_valid),
		.operand_stall (operand_stall),
		.operand       (operand),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.result        (result)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	initial begin
		#30000000;
		$display("TB_ERROR");
		$finish;
	end

	// accepted operand transactions
	always @(posedge clk) begin
		if (arst_n && operand_valid && !operand_stall)
			checker_h.note(operand);
	end

	// accepted result transactions
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			checker_h.check(result);
	end

	// receiver stall bursts
	initial begin
		result_stall = 1'b0;
		stall_left   = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 13) - 1;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// present one operand and hold it until taken
	task automatic send_operand(word_t value, word_t modulus);
		@(negedge clk);
		operand_valid <= 1'b1;
		operand       <= '{value: value, modulus: modulus};
		@(posedge clk);
		while (operand_stall)
			@(posedge clk);
	endtask

	// drop valid for a number of cycles, payload is noise
	task automatic hold_off(int cycles);
		@(negedge clk);
		operand_valid <= 1'b0;
		operand       <= {$urandom, $urandom};
		repeat (cycles - 1)
			@(negedge clk);
	endtask

	task automatic wait_all_results();
		while (checker_h.outstanding() != 0)
			@(posedge clk);
	endtask

	// random operand pair of a randomly chosen shape
	task automatic send_random();
		word_t value, modulus, factor;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				value   = $urandom;
				modulus = $urandom;
			end
			4: begin
				value   = $urandom;
				modulus = $urandom_range(0, 20);
			end
			5: begin
				value   = $urandom_range(0, 50);
				modulus = $urandom_range(0, 50);
			end
			6: begin
				// shared factor, mostly no inverse
				factor  = $urandom_range(2, 1000);
				value   = factor * $urandom_range(0, 4000000);
				modulus = factor * $urandom_range(0, 4000000);
			end
			7: begin
				// value above modulus
				modulus = $urandom_range(1, 32'h7fff_ffff);
				value   = modulus + $urandom_range(1, 32'h7fff_ffff);
			end
			8: begin
				value   = $urandom_range(0, 1000);
				modulus = $urandom | 32'h8000_0001;
			end
			default: begin
				value   = ($urandom_range(0, 1)) ? WORD_MAX - $urandom_range(0, 2)
				                                 : $urandom_range(0, 2);
				modulus = ($urandom_range(0, 1)) ? WORD_MAX - $urandom_range(0, 2)
				                                 : $urandom_range(0, 2);
			end
		endcase
		send_operand(value, modulus);
	endtask

	// main sequence
	initial begin
		checker_h     = new();
		calm          = 1'b0;
		arst_n        = 1'b0;
		operand_valid = 1'b0;
		operand       = '0;
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: zero and unit moduli, zero value, extremes, no inverse, longest chain
		send_operand(32'd0, 32'd0);
		send_operand(32'd0, 32'd1);
		send_operand(32'd0, 32'd12);
		send_operand(32'd1, 32'd0);
		send_operand(32'd9, 32'd0);
		send_operand(32'd17, 32'd1);
		send_operand(32'd1, 32'd1);
		send_operand(32'd3, 32'd7);
		send_operand(32'd6, 32'd9);
		send_operand(32'd4, 32'd2);
		send_operand(WORD_MAX, WORD_MAX);
		send_operand(WORD_MAX, 32'd0);
		send_operand(32'd0, WORD_MAX);
		send_operand(WORD_MAX, WORD_MAX - 32'd1);
		send_operand(WORD_MAX - 32'd1, WORD_MAX);
		send_operand(32'd2, WORD_MAX);
		send_operand(32'd1836311903, 32'd2971215073);
		send_operand(32'd2971215073, 32'd1836311903);
		send_operand(32'h8000_0000, 32'h7fff_ffff);
		send_operand(32'd1, WORD_MAX);
		hold_off(1);
		wait_all_results();

		// random part with sender gaps, quiet toward the end
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			calm = (n >= RANDOM_ITEMS - CALM_TAIL);
			if (n == RANDOM_ITEMS / 2) begin
				hold_off(1);
				wait_all_results();
			end
			if (!calm && $urandom_range(0, 3) == 0)
				hold_off($urandom_range(1, 13));
			send_random();
		end

		@(negedge clk);
		operand_valid <= 1'b0;
		wait_all_results();
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		$display("covered %0d directed and %0d random operands: %0d invertible, %0d not",
			20, RANDOM_ITEMS, checker_h.with_inverse, checker_h.without_inverse);
		if (checker_h.mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/modinv_pkg.sv
hw/rtl/modinv_ctrl.sv
hw/rtl/modinv_dp.sv
hw/rtl/modular_inverse_32.sv
tb/testbench.sv
